@@ src/pcgbr_pkg.sv @@
// shared constants and mixing function for the bounded random generator
package pcgbr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_W - 1);

    localparam logic [WORD_W-1:0] STEP_MULT = 32'h4C95_7F2D;
    localparam logic [WORD_W-1:0] STEP_INC  = 32'hF767_814F;
    localparam int unsigned MIX_SHIFT = 18;
    localparam int unsigned ROT_SHIFT = 27;

    typedef logic [WORD_W-1:0] word_t;

    // xorshift then rotate right by the top five bits
    function automatic word_t mix_rotate(input word_t x);
        word_t                    m;
        logic [CNT_W-1:0]         r;
        logic [2*WORD_W-1:0]      dbl;
        m   = x ^ (x >> MIX_SHIFT);
        r   = m[WORD_W-1:ROT_SHIFT];
        dbl = {m, m} >> r;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

@@ src/pcgbr_mul.sv @@
// bit-serial state advance: state * multiplier + increment
module pcgbr_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  pcgbr_pkg::word_t     state_in,
    output logic                 done,
    output pcgbr_pkg::word_t     state_out
);
    import pcgbr_pkg::*;

    word_t            acc_reg, acc_next;
    word_t            mcand_reg, mcand_next;
    word_t            mplier_reg, mplier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = STEP_INC;
            mcand_next  = STEP_MULT;
            mplier_next = state_in;
            cnt_next    = '0;
            active_next = 1'b1;
        end else if (active_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[WORD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[WORD_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done      = done_reg;
    assign state_out = acc_reg;

endmodule

@@ src/pcgbr_div.sv @@
// bit-serial restoring remainder unit, zero divisor gives the dividend
module pcgbr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  pcgbr_pkg::word_t     dividend,
    input  pcgbr_pkg::word_t     divisor,
    output logic                 done,
    output pcgbr_pkg::word_t     remainder
);
    import pcgbr_pkg::*;

    word_t             rem_reg, rem_next;
    word_t             dvd_reg, dvd_next;
    word_t             dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] trial;

    always_comb begin
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        shifted     = {rem_reg, dvd_reg[WORD_W-1]};
        trial       = {1'b0, shifted} - {2'b00, dvs_reg};
        if (start) begin
            rem_next    = '0;
            dvd_next    = dividend;
            dvs_next    = divisor;
            cnt_next    = '0;
            active_next = 1'b1;
        end else if (active_reg) begin
            rem_next = trial[WORD_W+1] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ src/pcg_style_bounded_random.sv @@
// top level of the bounded random generator
//
// s_ channel: one request per item, s_tdata holds lower_bound (bits 31:0)
// and upper_bound (bits 63:32), both signed
// m_ channel: one result per request, m_tdata holds raw_value (bits 31:0)
// and bounded_value (bits 63:32)
// cfg_wr_en/cfg_wr_data: writes the seed and reloads the generator state,
// only while no request is in flight
// a request passes from acceptance to m_tvalid through one pass of the
// bit-serial remainder unit, with the bit-serial state multiplier
// running alongside, a step to commit the advanced state (S_BUSY), and
// the step that lands it in the output register (S_HOLD)
// one request is in flight at a time, so a new request is taken only
// once the last has left the core; s_tready returns high the cycle the
// result is registered, so the next request overlaps the output wait
// a stalled receiver holds the result in the output register; a finished
// request waits in the core until the register is free
// reset clears the seed and state to zero and empties the output register
module pcg_style_bounded_random (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // lower_bound, upper_bound
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // raw_value, bounded_value
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import pcgbr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    word_t  gen_reg, gen_next;
    word_t  raw_reg, raw_next;
    word_t  lo_reg, lo_next;
    word_t  out_raw_reg, out_raw_next;
    word_t  out_bnd_reg, out_bnd_next;
    logic   out_vld_reg, out_vld_next;

    logic   accept;
    word_t  raw_comb;
    word_t  span_comb;
    logic   div_done, mul_done;
    word_t  rem;
    word_t  gen_adv;
    logic   slot_free;

    assign accept    = s_tvalid && s_tready;
    assign raw_comb  = mix_rotate(gen_reg);
    assign span_comb = s_tdata[63:32] - s_tdata[31:0] + 1'b1;
    assign slot_free = !out_vld_reg || m_tready;

    pcgbr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (raw_comb),
        .divisor   (span_comb),
        .done      (div_done),
        .remainder (rem)
    );

    pcgbr_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .state_in  (gen_reg),
        .done      (mul_done),
        .state_out (gen_adv)
    );

    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        raw_next     = raw_reg;
        lo_next      = lo_reg;
        out_raw_next = out_raw_reg;
        out_bnd_next = out_bnd_reg;
        out_vld_next = out_vld_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (cfg_wr_en) begin
                    gen_next = cfg_wr_data;
                end
                if (accept) begin
                    raw_next   = raw_comb;
                    lo_next    = s_tdata[31:0];
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                if (div_done && mul_done) begin
                    gen_next   = gen_adv;
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    out_raw_next = raw_reg;
                    out_bnd_next = lo_reg + rem;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            gen_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            out_vld_reg <= out_vld_next;
        end
        raw_reg     <= raw_next;
        lo_reg      <= lo_next;
        out_raw_reg <= out_raw_next;
        out_bnd_reg <= out_bnd_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_bnd_reg, out_raw_reg};

endmodule

@@ src/pcgbr_chk.sv @@
// port-level checks for the bounded random generator, bound to the top level
module pcgbr_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another in flight");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind pcg_style_bounded_random pcgbr_chk u_chk (.*);
